### hdl/brbv_pkg.sv
`default_nettype none

package brbv_pkg;

   // Result codes carried in the status field.
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_POPULATION = 3'd1;
   localparam logic [2:0] STATUS_TRAILING   = 3'd2;
   localparam logic [2:0] STATUS_TRUNCATED  = 3'd3;
   localparam logic [2:0] STATUS_SPLIT      = 3'd4;
   localparam logic [2:0] STATUS_RANK       = 3'd5;
   localparam logic [2:0] STATUS_PADDING    = 3'd6;

   // Largest legal population of the 256-bit set.
   localparam logic [8:0] POPULATION_MAX = 9'd256;
   // Span of the root's children.
   localparam logic [8:0] ROOT_HALF = 9'd128;
   // First rank field; split fields sit below it.
   localparam int LEAF_FIRST = 32;

   // Node counts are stored in rows of sibling pairs: row r holds nodes 2r and 2r+1.
   localparam int NODE_WIDTH = 9;
   localparam int ROW_WIDTH  = 2 * NODE_WIDTH;
   localparam int ROW_COUNT  = 32;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_EXEC,
      SEQ_APPEND,
      SEQ_FINISH
   } seq_state_type;

   // Number of bits needed to hold a value (zero for zero).
   function automatic logic [3:0] width_of(input logic [8:0] value);
      logic [3:0] result;
      result = 4'd0;
      for (int i = 0; i < 9; i++) begin
         if (value[i]) begin
            result = 4'(i + 1);
         end
      end
      return result;
   endfunction

   // Rank field width of a leaf holding k set bits: bit_width(C(8,k) - 1).
   function automatic logic [3:0] leaf_width(input logic [3:0] k);
      logic [3:0] result;
      case (k)
         4'd1, 4'd7: result = 4'd3;
         4'd2, 4'd6: result = 4'd5;
         4'd3, 4'd5: result = 4'd6;
         4'd4:       result = 4'd7;
         default:    result = 4'd0;
      endcase
      return result;
   endfunction

   // Number of distinct 8-bit patterns with k set bits: C(8,k).
   function automatic logic [6:0] leaf_choices(input logic [3:0] k);
      logic [6:0] result;
      case (k)
         4'd1, 4'd7: result = 7'd8;
         4'd2, 4'd6: result = 7'd28;
         4'd3, 4'd5: result = 7'd56;
         4'd4:       result = 7'd70;
         default:    result = 7'd1;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

### hdl/brbv_if.sv
`default_nettype none

interface brbv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       byte_present;
   logic [8:0] population;
   logic       last_byte;

   modport source (output valid, body_byte, byte_present, population, last_byte,
                   input ready);
   modport sink (input valid, body_byte, byte_present, population, last_byte,
                 output ready);
endinterface

interface brbv_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;

   modport source (output valid, status, input ready);
   modport sink (input valid, status, output ready);
endinterface

`default_nettype wire

### hdl/bisection_rank_body_validator_core.sv
// Channel   Direction  Payload                                         Accepted when
// req_chan  in         body_byte, byte_present, population, last_byte  valid && ready
// rsp_chan  out        status                                          valid && ready
//
// After an item is taken the block is busy with an append step, a read and an execute for
// each field it completes, and a finish step. Before the finish step may come a read that
// finds decoding stopped, a read and an execute when a field lacks bits, or a read and an
// execute that flag a field error and then such a read. The first item of a body first
// runs its own field pass, and it skips the append step when it carries no byte. Reset is
// synchronous and clears the sequencer, the body flag and the result valid; the node
// memory is never cleared. A waiting result blocks nothing until a last item reaches its
// finish step, which holds there until the previous result has been taken.

`default_nettype none

module bisection_rank_body_validator_core #(
   parameter int MAX_BODY_BYTES = 64
) (
   input wire logic clock,
   input wire logic reset,
   brbv_req_if.sink   req_chan,
   brbv_rsp_if.source rsp_chan
);

   // The byte counter saturates at the body limit, so it only needs to hold that value.
   localparam int BytesWidth = $clog2(MAX_BODY_BYTES + 1);
   localparam int RowAddrWidth = $clog2(brbv_pkg::ROW_COUNT);

   brbv_pkg::seq_state_type state_ff, state_in;

   // Body state.
   logic [8:0]            population_ff, population_in;
   logic [15:0]           bit_buffer_ff, bit_buffer_in;
   logic [4:0]            buffered_bits_ff, buffered_bits_in;
   logic [6:0]            field_cursor_ff, field_cursor_in;
   logic [BytesWidth-1:0] bytes_seen_ff, bytes_seen_in;
   logic                  oversize_ff, oversize_in;
   logic [2:0]            first_error_ff, first_error_in;
   logic                  in_body_ff, in_body_in;

   // The item under work.
   logic [7:0] body_byte_ff, body_byte_in;
   logic       byte_pending_ff, byte_pending_in;
   logic       last_byte_ff, last_byte_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;

   // Node count memory ports.
   logic                          ram_wr_en;
   logic [RowAddrWidth-1:0]       ram_wr_addr;
   logic [brbv_pkg::ROW_WIDTH-1:0] ram_wr_data;
   logic                          ram_rd_en;
   logic [brbv_pkg::ROW_WIDTH-1:0] ram_rd_data;

   brbv_ram #(
      .WIDTH(brbv_pkg::ROW_WIDTH),
      .DEPTH(brbv_pkg::ROW_COUNT)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(field_cursor_ff[5:1]),
      .rd_data(ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Shared field unit. It works on the field named by the cursor, with
   // that node's count taken from the memory (the root comes from the
   // population register, since it never lands in the memory).
   // ------------------------------------------------------------------
   logic [8:0]  node_count;
   logic        is_split;
   logic [3:0]  split_level;
   logic [8:0]  half_span;
   logic [8:0]  full_span;
   logic [8:0]  split_alt;
   logic [3:0]  leaf_k;
   logic [3:0]  field_width;
   logic [15:0] field_mask;
   logic [8:0]  field_value;
   logic        field_stall;
   logic        split_error;
   logic        rank_error;
   logic [8:0]  left_count;
   logic [8:0]  right_count;
   logic        body_stop;
   logic        population_bad;

   assign population_bad = population_ff > brbv_pkg::POPULATION_MAX;

   always_comb begin
      if (field_cursor_ff == 7'd1) begin
         node_count = population_ff;
      end else if (field_cursor_ff[0]) begin
         node_count = ram_rd_data[brbv_pkg::ROW_WIDTH-1:brbv_pkg::NODE_WIDTH];
      end else begin
         node_count = ram_rd_data[brbv_pkg::NODE_WIDTH-1:0];
      end

      is_split = field_cursor_ff < 7'(brbv_pkg::LEAF_FIRST);

      // Depth of the split node in the tree sets the span it divides.
      split_level = brbv_pkg::width_of({4'd0, field_cursor_ff[4:0]}) - 4'd1;
      half_span   = brbv_pkg::ROOT_HALF >> split_level;
      full_span   = half_span << 1;

      // The left count can only range over the smaller of p and span - p.
      if (node_count <= full_span) begin
         split_alt = (node_count < (full_span - node_count)) ? node_count
                                                             : (full_span - node_count);
      end else begin
         split_alt = 9'd0;
      end

      // A leaf count above eight cannot follow from valid splits; clamp it anyway.
      leaf_k = (node_count > 9'd8) ? 4'd8 : node_count[3:0];

      field_width = is_split ? brbv_pkg::width_of(split_alt) : brbv_pkg::leaf_width(leaf_k);
      field_mask  = (16'd1 << field_width) - 16'd1;
      field_value = {1'b0, bit_buffer_ff[7:0] & field_mask[7:0]};
      field_stall = {1'b0, field_width} > buffered_bits_ff;

      split_error = field_value > split_alt;
      rank_error  = field_value >= {2'd0, brbv_pkg::leaf_choices(leaf_k)};

      left_count  = field_value + ((node_count > half_span) ? (node_count - half_span) : 9'd0);
      right_count = node_count - left_count;

      // Field decoding stops on an error, at the end of all fields, or on a bad population.
      body_stop = (first_error_ff != brbv_pkg::STATUS_OK) || field_cursor_ff[6]
                  || population_bad;
   end

   // ------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brbv_pkg::SEQ_IDLE;
         in_body_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_body_ff   <= in_body_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      population_ff    <= population_in;
      bit_buffer_ff    <= bit_buffer_in;
      buffered_bits_ff <= buffered_bits_in;
      field_cursor_ff  <= field_cursor_in;
      bytes_seen_ff    <= bytes_seen_in;
      oversize_ff      <= oversize_in;
      first_error_ff   <= first_error_in;
      body_byte_ff     <= body_byte_in;
      byte_pending_ff  <= byte_pending_in;
      last_byte_ff     <= last_byte_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign req_chan.ready  = (state_ff == brbv_pkg::SEQ_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;

   always_comb begin
      state_in         = state_ff;
      population_in    = population_ff;
      bit_buffer_in    = bit_buffer_ff;
      buffered_bits_in = buffered_bits_ff;
      field_cursor_in  = field_cursor_ff;
      bytes_seen_in    = bytes_seen_ff;
      oversize_in      = oversize_ff;
      first_error_in   = first_error_ff;
      in_body_in       = in_body_ff;
      body_byte_in     = body_byte_ff;
      byte_pending_in  = byte_pending_ff;
      last_byte_in     = last_byte_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;

      ram_wr_en   = 1'b0;
      ram_wr_addr = field_cursor_ff[RowAddrWidth-1:0];
      ram_wr_data = {right_count, left_count};
      ram_rd_en   = 1'b0;

      unique case (state_ff)
         brbv_pkg::SEQ_IDLE: begin
            if (req_chan.valid) begin
               body_byte_in    = req_chan.body_byte;
               byte_pending_in = req_chan.byte_present;
               last_byte_in    = req_chan.last_byte;
               if (!in_body_ff) begin
                  // First item of a body: sample the population and run the
                  // zero-width fields before this item's byte is taken in.
                  population_in    = req_chan.population;
                  bit_buffer_in    = 16'd0;
                  buffered_bits_in = 5'd0;
                  field_cursor_in  = 7'd1;
                  bytes_seen_in    = '0;
                  oversize_in      = 1'b0;
                  first_error_in   = brbv_pkg::STATUS_OK;
                  in_body_in       = 1'b1;
                  state_in         = brbv_pkg::SEQ_READ;
               end else begin
                  state_in = brbv_pkg::SEQ_APPEND;
               end
            end
         end

         brbv_pkg::SEQ_READ: begin
            if (body_stop) begin
               state_in = byte_pending_ff ? brbv_pkg::SEQ_APPEND : brbv_pkg::SEQ_FINISH;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = brbv_pkg::SEQ_EXEC;
            end
         end

         brbv_pkg::SEQ_EXEC: begin
            if (field_stall) begin
               // Not enough bits buffered yet: wait for the next byte.
               state_in = byte_pending_ff ? brbv_pkg::SEQ_APPEND : brbv_pkg::SEQ_FINISH;
            end else begin
               state_in = brbv_pkg::SEQ_READ;
               if (is_split && split_error) begin
                  first_error_in = brbv_pkg::STATUS_SPLIT;
               end else if (!is_split && rank_error) begin
                  first_error_in = brbv_pkg::STATUS_RANK;
               end else begin
                  bit_buffer_in    = bit_buffer_ff >> field_width;
                  buffered_bits_in = buffered_bits_ff - {1'b0, field_width};
                  field_cursor_in  = field_cursor_ff + 7'd1;
                  ram_wr_en        = is_split;
               end
            end
         end

         brbv_pkg::SEQ_APPEND: begin
            byte_pending_in = 1'b0;
            state_in        = brbv_pkg::SEQ_FINISH;
            if (byte_pending_ff) begin
               // Every byte counts toward the size limit, even one the decoder ignores.
               if (bytes_seen_ff >= BytesWidth'(MAX_BODY_BYTES)) begin
                  oversize_in = 1'b1;
               end else begin
                  bytes_seen_in = bytes_seen_ff + 1'b1;
               end
               if ((first_error_ff == brbv_pkg::STATUS_OK) && !population_bad) begin
                  if (field_cursor_ff[6]) begin
                     first_error_in = brbv_pkg::STATUS_TRAILING;
                  end else begin
                     bit_buffer_in    = bit_buffer_ff | (16'(body_byte_ff) << buffered_bits_ff);
                     buffered_bits_in = buffered_bits_ff + 5'd8;
                     state_in         = brbv_pkg::SEQ_READ;
                  end
               end
            end
         end

         brbv_pkg::SEQ_FINISH: begin
            if (!last_byte_ff) begin
               state_in = brbv_pkg::SEQ_IDLE;
            end else if (!rsp_valid_ff || rsp_chan.ready) begin
               // Report the first error by priority and close the body.
               if (population_bad) begin
                  rsp_status_in = brbv_pkg::STATUS_POPULATION;
               end else if (oversize_ff) begin
                  rsp_status_in = brbv_pkg::STATUS_TRAILING;
               end else if (first_error_ff != brbv_pkg::STATUS_OK) begin
                  rsp_status_in = first_error_ff;
               end else if (!field_cursor_ff[6]) begin
                  rsp_status_in = brbv_pkg::STATUS_TRUNCATED;
               end else if (bit_buffer_ff != 16'd0) begin
                  rsp_status_in = brbv_pkg::STATUS_PADDING;
               end else begin
                  rsp_status_in = brbv_pkg::STATUS_OK;
               end
               rsp_valid_in = 1'b1;
               in_body_in   = 1'b0;
               state_in     = brbv_pkg::SEQ_IDLE;
            end
         end

         default: begin
            state_in = brbv_pkg::SEQ_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hdl/brbv_ram.sv
`default_nettype none

module brbv_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hdl/brbv_checker.sv
`default_nettype none

module brbv_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_status
);

   // A result that is not taken stays offered with the same status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped or changed while stalled");

   // Once an item is taken the sequencer is busy, so it is not ready in the cycle after.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted on consecutive cycles");

   // A new result is only produced from the finish step, never while idle.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a busy sequencer");

   // Status code seven is never produced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 3'd7)
      else $error("undefined status code");

endmodule

bind bisection_rank_body_validator_core brbv_checker u_brbv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_status(rsp_chan.status)
);

`default_nettype wire

### verif/bisection_rank_body_validator_checker.sv
// Watches both channels of the body validator, predicts the status of every body
// and compares each returned status with the oldest outstanding prediction.
module bisection_rank_body_validator_checker #(
   parameter int MAX_BODY_BYTES = 64
) (
   input wire logic clock,
   input wire logic reset,
   brbv_req_if      req_chan,
   brbv_rsp_if      rsp_chan,
   output int       fail_count,
   output int       pending_count,
   output int       checked_count
);

   localparam logic [6:0] FIELDS_DONE = 7'd64;

   // Decoder state of the body in progress.
   logic [8:0]  node_count [64];
   logic [15:0] bits_held;
   logic [4:0]  bits_held_count;
   logic [6:0]  next_field;
   logic [7:0]  byte_count;
   logic        body_too_long;
   logic [2:0]  body_error;
   logic        body_open;

   logic [2:0]  expected_status_q [$];
   int          mismatches;
   int          results_seen;

   function automatic int bits_for(input int value);
      int n;
      n = 0;
      while (value != 0) begin
         n++;
         value = value >> 1;
      end
      return n;
   endfunction

   // Width of the rank field of a leaf with k set bits.
   function automatic int rank_bits(input int k);
      case (k)
         1, 7:    return 3;
         2, 6:    return 5;
         3, 5:    return 6;
         4:       return 7;
         default: return 0;
      endcase
   endfunction

   // Number of legal ranks of a leaf with k set bits.
   function automatic int rank_limit(input int k);
      case (k)
         1, 7:    return 8;
         2, 6:    return 28;
         3, 5:    return 56;
         4:       return 70;
         default: return 1;
      endcase
   endfunction

   function automatic int pull_bits(input int w);
      int v;
      v = int'(bits_held) & ((1 << w) - 1);
      bits_held = bits_held >> w;
      bits_held_count = bits_held_count - 5'(w);
      return v;
   endfunction

   // Decodes as many fields as the buffered bits allow, stopping at the first error.
   task automatic advance_fields();
      int   c;
      int   p;
      int   half;
      int   span;
      int   alt;
      int   w;
      int   v;
      int   left;
      int   k;
      logic stop;
      stop = (node_count[1] > brbv_pkg::POPULATION_MAX);
      while (!stop && body_error == brbv_pkg::STATUS_OK && next_field < FIELDS_DONE) begin
         c = int'(next_field);
         p = int'(node_count[c]);
         if (c < brbv_pkg::LEAF_FIRST) begin
            half = 128 >> (bits_for(c) - 1);
            span = 2 * half;
            alt = 0;
            if (p <= span) begin
               alt = (p < span - p) ? p : span - p;
            end
            w = bits_for(alt);
            if (w > int'(bits_held_count)) begin
               stop = 1'b1;
            end else begin
               v = pull_bits(w);
               if (v > alt) begin
                  body_error = brbv_pkg::STATUS_SPLIT;
                  stop = 1'b1;
               end else begin
                  left = v + ((p > half) ? p - half : 0);
                  node_count[2 * c] = 9'(left);
                  node_count[2 * c + 1] = 9'(p - left);
               end
            end
         end else begin
            k = (p > 8) ? 8 : p;
            w = rank_bits(k);
            if (w > int'(bits_held_count)) begin
               stop = 1'b1;
            end else begin
               v = pull_bits(w);
               if (v >= rank_limit(k)) begin
                  body_error = brbv_pkg::STATUS_RANK;
                  stop = 1'b1;
               end
            end
         end
         if (!stop) begin
            next_field = 7'(c + 1);
         end
      end
   endtask

   // Applies one accepted item; a last item queues the predicted status.
   task automatic take_item(input logic [7:0] data, input logic present,
                            input logic [8:0] population, input logic last);
      logic [2:0] status;
      if (!body_open) begin
         node_count[1] = population;
         bits_held = '0;
         bits_held_count = '0;
         next_field = 7'd1;
         byte_count = '0;
         body_too_long = 1'b0;
         body_error = brbv_pkg::STATUS_OK;
         body_open = 1'b1;
         advance_fields();
      end
      if (present) begin
         if (byte_count >= MAX_BODY_BYTES) begin
            body_too_long = 1'b1;
         end else begin
            byte_count++;
         end
         if (body_error == brbv_pkg::STATUS_OK && node_count[1] <= brbv_pkg::POPULATION_MAX)
         begin
            if (next_field >= FIELDS_DONE) begin
               body_error = brbv_pkg::STATUS_TRAILING;
            end else begin
               bits_held = bits_held | (16'(data) << bits_held_count);
               bits_held_count = bits_held_count + 5'd8;
               advance_fields();
            end
         end
      end
      if (last) begin
         if (node_count[1] > brbv_pkg::POPULATION_MAX) begin
            status = brbv_pkg::STATUS_POPULATION;
         end else if (body_too_long) begin
            status = brbv_pkg::STATUS_TRAILING;
         end else if (body_error != brbv_pkg::STATUS_OK) begin
            status = body_error;
         end else if (next_field < FIELDS_DONE) begin
            status = brbv_pkg::STATUS_TRUNCATED;
         end else if (bits_held != '0) begin
            status = brbv_pkg::STATUS_PADDING;
         end else begin
            status = brbv_pkg::STATUS_OK;
         end
         expected_status_q.push_back(status);
         body_open = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      logic [2:0] wanted;
      if (reset) begin
         body_open = 1'b0;
         expected_status_q.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            take_item(req_chan.body_byte, req_chan.byte_present, req_chan.population,
                      req_chan.last_byte);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (expected_status_q.size() == 0) begin
               if (mismatches < 10) begin
                  $display("Unexpected result, status %0d, with nothing outstanding",
                           rsp_chan.status);
               end
               mismatches++;
            end else begin
               wanted = expected_status_q.pop_front();
               if (rsp_chan.status !== wanted) begin
                  if (mismatches < 10) begin
                     $display("Status mismatch on result %0d: expected %0d, got %0d",
                              results_seen, wanted, rsp_chan.status);
                  end
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      pending_count <= expected_status_q.size();
      checked_count <= results_seen;
   end

endmodule

### verif/bisection_rank_body_validator_core_tb.sv
// Stimulus and verdict for the body validator. The checker beside the block does
// all prediction; this module only builds bodies, drives them and judges the run.
module bisection_rank_body_validator_core_tb;

   localparam int BODY_LIMIT     = 64;
   localparam int RANDOM_ITEMS   = 360;
   localparam int WATCHDOG_LIMIT = 4000;
   // A first item with only zero-width fields runs all 63 fields in one go; the drain
   // below allows that with room to spare.
   localparam int DRAIN_CYCLES   = 300;

   // Ways in which a generated body departs from a well-formed encoding.
   typedef enum int {
      FAULT_NONE,
      FAULT_SPLIT,
      FAULT_RANK,
      FAULT_PADDING,
      FAULT_TRUNCATE,
      FAULT_TRAILING,
      FAULT_OVERSIZE,
      FAULT_NOISE
   } body_fault_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic steady = 1'b0;

   int fail_count;
   int pending_count;
   int checked_count;
   int items_counted = 0;
   int bodies_sent = 0;
   int faulty_bodies = 0;
   int stall_cycles = 0;

   // Fields of the body being built, in decode order, and the bytes that carry them.
   int         field_value [$];
   int         field_width [$];
   int         field_max [$];
   logic [7:0] body_bytes [$];

   brbv_req_if req_chan ();
   brbv_rsp_if rsp_chan ();

   bisection_rank_body_validator_core #(
      .MAX_BODY_BYTES(BODY_LIMIT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   bisection_rank_body_validator_checker #(
      .MAX_BODY_BYTES(BODY_LIMIT)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .fail_count(fail_count),
      .pending_count(pending_count),
      .checked_count(checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The result side stalls in about one cycle out of six, except during the
   // steady stretch in the middle of the random part.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= steady || ($urandom_range(99) >= 16);
      end
   end

   // The watchdog ends the run if neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no item moved on either channel for %0d cycles", WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic int value_bits(input int value);
      int n;
      n = 0;
      for (int v = value; v != 0; v = v >> 1) begin
         n++;
      end
      return n;
   endfunction

   // Count of 8-bit patterns with k ones, worked out directly rather than looked up.
   function automatic int leaf_patterns(input int k);
      int n;
      n = 1;
      for (int i = 0; i < k; i++) begin
         n = n * (8 - i) / (i + 1);
      end
      return n;
   endfunction

   // Builds a legal field list for a set of the given population: 31 split fields
   // breadth first, then 32 rank fields. Splits favor their extremes so that leaves
   // often end up empty or full.
   task automatic encode_fields(input int population);
      int count [64];
      int half;
      int span;
      int alt;
      int v;
      int left;
      int lim;
      field_value.delete();
      field_width.delete();
      field_max.delete();
      count[1] = population;
      for (int c = 1; c < 32; c++) begin
         half = 128 >> (value_bits(c) - 1);
         span = 2 * half;
         alt = (count[c] < span - count[c]) ? count[c] : span - count[c];
         case ($urandom_range(3))
            0:       v = 0;
            1:       v = alt;
            default: v = $urandom_range(alt, 0);
         endcase
         left = v + ((count[c] > half) ? count[c] - half : 0);
         count[2 * c] = left;
         count[2 * c + 1] = count[c] - left;
         field_value.push_back(v);
         field_width.push_back(value_bits(alt));
         field_max.push_back(alt);
      end
      for (int c = 32; c < 64; c++) begin
         lim = leaf_patterns(count[c]) - 1;
         field_value.push_back($urandom_range(lim, 0));
         field_width.push_back(value_bits(lim));
         field_max.push_back(lim);
      end
   endtask

   // Pushes one field in the given index range past its legal maximum. A field can
   // only be broken when its width leaves room above the maximum.
   function automatic void break_one_field(input int first, input int past);
      int candidates [$];
      int pick;
      for (int i = first; i < past; i++) begin
         if (field_max[i] < (1 << field_width[i]) - 1) begin
            candidates.push_back(i);
         end
      end
      if (candidates.size() != 0) begin
         pick = candidates[$urandom_range(candidates.size() - 1)];
         field_value[pick] = $urandom_range((1 << field_width[pick]) - 1, field_max[pick] + 1);
      end
   endfunction

   // Packs the fields into bytes, least significant bit first. The spare bits of the
   // last byte are zero unless dirty padding is asked for.
   task automatic pack_fields(input bit dirty_pad);
      logic [7:0] cur;
      int         fill;
      body_bytes.delete();
      cur = '0;
      fill = 0;
      for (int i = 0; i < field_value.size(); i++) begin
         for (int b = 0; b < field_width[i]; b++) begin
            cur[fill] = field_value[i][b];
            fill++;
            if (fill == 8) begin
               body_bytes.push_back(cur);
               cur = '0;
               fill = 0;
            end
         end
      end
      if (fill != 0) begin
         if (dirty_pad) begin
            cur = cur | 8'($urandom_range((1 << (8 - fill)) - 1, 1) << fill);
         end
         body_bytes.push_back(cur);
      end
   endtask

   // Offers one item and holds it until the block takes it. Idle cycles go in front
   // of the item, so valid is lowered only where no item follows in the same cycle.
   task automatic send_item(input logic [7:0] data, input logic present,
                            input logic [8:0] population, input logic last);
      while (!steady && $urandom_range(99) < 16) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.body_byte <= data;
      req_chan.byte_present <= present;
      req_chan.population <= population;
      req_chan.last_byte <= last;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      items_counted++;
   endtask

   // Builds and sends one body. The population rides on the first item only; the
   // later items carry random populations that the block must ignore. Holes are
   // items without a byte inside the body, and an open end closes the body with an
   // empty last item instead of marking the final byte.
   task automatic send_body(input int population, input body_fault_type fault,
                            input bit holes, input bit open_end);
      int   extra;
      int   target;
      logic first;
      if (population > 256 || fault == FAULT_NOISE) begin
         body_bytes.delete();
         repeat ($urandom_range(5)) begin
            body_bytes.push_back(8'($urandom));
         end
      end else begin
         encode_fields(population);
         if (fault == FAULT_SPLIT) begin
            break_one_field(0, 31);
         end
         if (fault == FAULT_RANK) begin
            break_one_field(31, 63);
         end
         pack_fields(fault == FAULT_PADDING);
      end
      case (fault)
         FAULT_TRUNCATE: begin
            if (body_bytes.size() != 0) begin
               extra = $urandom_range(1, (body_bytes.size() > 2) ? 2 : body_bytes.size());
               repeat (extra) begin
                  void'(body_bytes.pop_back());
               end
            end
         end
         FAULT_TRAILING: begin
            repeat ($urandom_range(3, 1)) begin
               body_bytes.push_back(8'($urandom));
            end
         end
         FAULT_OVERSIZE: begin
            target = BODY_LIMIT + 1 + $urandom_range(3);
            while (body_bytes.size() < target) begin
               body_bytes.push_back(8'($urandom));
            end
         end
         default: ;
      endcase
      first = 1'b1;
      foreach (body_bytes[i]) begin
         if (holes && $urandom_range(3) == 0) begin
            send_item(8'($urandom), 1'b0, first ? 9'(population) : 9'($urandom), 1'b0);
            first = 1'b0;
         end
         send_item(body_bytes[i], 1'b1, first ? 9'(population) : 9'($urandom),
                   !open_end && (i == body_bytes.size() - 1));
         first = 1'b0;
      end
      if (open_end || body_bytes.size() == 0) begin
         send_item(8'($urandom), 1'b0, first ? 9'(population) : 9'($urandom), 1'b1);
      end
      bodies_sent++;
      if (fault != FAULT_NONE) begin
         faulty_bodies++;
      end
   endtask

   // Most bodies are sparse or nearly full, which keeps them short; a few are dense
   // and run to about fifty bytes.
   function automatic int pick_population();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return $urandom_range(16);
         5, 6:          return $urandom_range(256, 240);
         7, 8:          return $urandom_range(64);
         default:       return $urandom_range(256);
      endcase
   endfunction

   initial begin
      int             roll;
      body_fault_type fault;
      req_chan.valid <= 1'b0;
      req_chan.body_byte <= '0;
      req_chan.byte_present <= 1'b0;
      req_chan.population <= '0;
      req_chan.last_byte <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Empty bodies whose fields all have zero width are legal, both
      // for the empty set and for the full one.
      send_body(0, FAULT_NONE, 1'b0, 1'b0);
      send_body(256, FAULT_NONE, 1'b0, 1'b0);
      // Populations above the set size are rejected before any field is read, with
      // or without a byte.
      send_item(8'h00, 1'b0, 9'd511, 1'b1);
      send_item(8'hFF, 1'b1, 9'd257, 1'b1);
      // An empty body that still owes fields is truncated.
      send_item(8'h00, 1'b0, 9'd7, 1'b1);
      // The empty set needs no bytes, so any byte is trailing.
      send_item(8'hA5, 1'b1, 9'd0, 1'b1);
      // Population five makes the root field three bits wide; seven is out of range.
      send_item(8'h07, 1'b1, 9'd5, 1'b1);
      // A single member fits in one byte exactly; holes must not disturb it.
      send_body(1, FAULT_NONE, 1'b1, 1'b0);
      send_body(2, FAULT_RANK, 1'b0, 1'b0);
      send_body(3, FAULT_PADDING, 1'b0, 1'b1);
      send_body(4, FAULT_TRUNCATE, 1'b0, 1'b0);
      send_body(2, FAULT_TRAILING, 1'b0, 1'b0);
      send_body(6, FAULT_SPLIT, 1'b0, 1'b0);

      // Random part: well-formed bodies with random content in just under half the rolls,
      // the rest broken in one way each or plain noise. A stretch in the middle runs with no
      // idling on either side.
      for (int limit = items_counted + RANDOM_ITEMS; items_counted < limit; ) begin
         steady <= (items_counted > limit - RANDOM_ITEMS + 150)
                   && (items_counted < limit - RANDOM_ITEMS + 240);
         roll = $urandom_range(99);
         if (roll < 48) begin
            fault = FAULT_NONE;
         end else if (roll < 58) begin
            fault = FAULT_SPLIT;
         end else if (roll < 66) begin
            fault = FAULT_RANK;
         end else if (roll < 72) begin
            fault = FAULT_PADDING;
         end else if (roll < 79) begin
            fault = FAULT_TRUNCATE;
         end else if (roll < 86) begin
            fault = FAULT_TRAILING;
         end else if (roll < 89) begin
            fault = FAULT_OVERSIZE;
         end else begin
            fault = FAULT_NOISE;
         end
         if (fault == FAULT_NOISE) begin
            send_body($urandom_range(511), fault, $urandom_range(1), $urandom_range(3) == 0);
         end else begin
            send_body(pick_population(), fault, $urandom_range(2) == 0,
                      $urandom_range(4) == 0);
         end
      end
      req_chan.valid <= 1'b0;
      steady <= 1'b0;

      // Wait for every predicted status, then give a stray result time to show up.
      do begin
         @(posedge clock);
      end while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d bodies in %0d items, %0d of them broken on purpose.",
               bodies_sent, items_counted, faulty_bodies);
      $display("Compared %0d status results; %0d mismatched, %0d never arrived.",
               checked_count, fail_count, pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/brbv_pkg.sv
hdl/brbv_if.sv
hdl/brbv_ram.sv
hdl/bisection_rank_body_validator_core.sv
hdl/brbv_checker.sv
verif/bisection_rank_body_validator_checker.sv
verif/bisection_rank_body_validator_core_tb.sv
